/* design/nllt_pkg.sv */
// ----------------------------------------------------------------------------
// nllt_pkg
// Shared codes and field widths for the node liveness and leader table.
// ----------------------------------------------------------------------------
`default_nettype none

package nllt_pkg;

	localparam int REQ_W     = 3;
	localparam int KIND_W    = 3;
	localparam int ID_W      = 8;
	localparam int QUAL_W    = 8;
	localparam int CHAN_W    = 7;
	localparam int TO_W      = 16;
	localparam int OUT_AGE_W = 16;

	localparam logic [REQ_W-1:0] REQ_JOIN  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_TELEM = 3'd1;
	localparam logic [REQ_W-1:0] REQ_TICK  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_EVAL  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

	localparam logic [KIND_W-1:0] KIND_JOIN_OK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LEADER   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 3'd4;

	localparam logic ADDR_TIMEOUT = 1'b0;
	localparam logic ADDR_CHANNEL = 1'b1;

endpackage

`default_nettype wire

/* design/nllt_store.sv */
// ----------------------------------------------------------------------------
// nllt_store
// Entry memory: online mark, link quality and age per node; one write and
// one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nllt_store #(
	parameter int DEPTH = 16,
	parameter int AGE_W = 16,
	parameter int IW    = 4
) (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire  [IW-1:0]                 wr_addr,
	input  wire                           wr_online,
	input  wire  [nllt_pkg::QUAL_W-1:0]   wr_qual,
	input  wire  [AGE_W-1:0]              wr_age,
	input  wire                           rd_en,
	input  wire  [IW-1:0]                 rd_addr,
	output logic                          rd_online,
	output logic [nllt_pkg::QUAL_W-1:0]   rd_qual,
	output logic [AGE_W-1:0]              rd_age
);

	localparam int EW = 1 + nllt_pkg::QUAL_W + AGE_W;

	logic [EW-1:0] mem_q [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_online, wr_qual, wr_age};
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_online = rd_q[EW-1];
	assign rd_qual   = rd_q[EW-2 -: nllt_pkg::QUAL_W];
	assign rd_age    = rd_q[AGE_W-1:0];

endmodule

`default_nettype wire

/* design/node_liveness_leader_table.sv */
// ----------------------------------------------------------------------------
// node_liveness_leader_table
// Member table with liveness ageing, leader election and status queries.
// ----------------------------------------------------------------------------
// One word in at a time: the input stalls while a word is being worked on.
// Telemetry is done in the cycle that accepts it. A join, a refused join or a
// query of an unknown id goes on to the emit state, and a query of a known id
// first passes the query-read state for the registered memory read. Tick and
// evaluate sweep the entry memory one entry per cycle. An evaluate then
// decides the leader in the finish state, and goes on to the emit state when
// it announces a new leader. A result waits
// in the output register while the next word is already taken. A word with
// a result of its own holds in its last cycle until that register is free.
// The memory is not cleared: entries above the fill count are never read,
// and a join writes its entry before first use.
`default_nettype none

module node_liveness_leader_table #(
	parameter int MAX_NODES = 16,
	parameter int AGE_WIDTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// slave: tdata = node_id[7:0], quality_in[15:8]; tuser = req_type[2:0]
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,
	input  wire  [2:0]  s_tuser,
	// master: tdata = result_id[7:0], leader_id[15:8], channel_out[22:16],
	// online_out[23], quality_out[31:24], age_out[47:32]; tuser = result_kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,
	output logic [2:0]  m_tuser,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int CW    = (AGE_WIDTH > 16) ? AGE_WIDTH : 16;
	localparam int ID_W  = nllt_pkg::ID_W;
	localparam int QW    = nllt_pkg::QUAL_W;
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

	typedef enum logic [2:0] {ST_IDLE, ST_QRD, ST_WALK, ST_FIN, ST_EMIT} state_t;

	state_t                          state_q;
	logic                            is_eval_q;
	logic [CNT_W-1:0]                idx_q;
	logic                            vld_s1;
	logic [IW-1:0]                   idx_s1;
	logic [CNT_W-1:0]                count_q;
	logic [ID_W-1:0]                 leader_q;
	logic                            leader_valid_q;
	logic [nllt_pkg::TO_W-1:0]       timeout_q;
	logic [nllt_pkg::CHAN_W-1:0]     chan_q;
	logic                            lead_on_q;
	logic                            found_q;
	logic [IW-1:0]                   best_idx_q;
	logic [AGE_WIDTH-1:0]            best_age_q;

	logic [nllt_pkg::KIND_W-1:0]     res_kind_q;
	logic [ID_W-1:0]                 res_id_q;
	logic [ID_W-1:0]                 res_leader_q;
	logic [nllt_pkg::CHAN_W-1:0]     res_chan_q;
	logic                            res_online_q;
	logic [QW-1:0]                   res_qual_q;
	logic [nllt_pkg::OUT_AGE_W-1:0]  res_age_q;

	logic                            wr_en;
	logic [IW-1:0]                   wr_addr;
	logic                            wr_online;
	logic [QW-1:0]                   wr_qual;
	logic [AGE_WIDTH-1:0]            wr_age;
	logic                            rd_en;
	logic [IW-1:0]                   rd_addr;
	logic                            rd_online;
	logic [QW-1:0]                   rd_qual;
	logic [AGE_WIDTH-1:0]            rd_age;

	logic [ID_W-1:0]                 in_id;
	logic [QW-1:0]                   in_qual;
	logic [ID_W-1:0]                 id_m1;
	logic                            id_known;
	logic [ID_W-1:0]                 cur_leader;
	logic [CW-1:0]                   age_ext;
	logic                            age_online;
	logic [ID_W-1:0]                 s1_id;
	logic                            accept;
	logic                            cfg_wr;

	assign in_id      = s_tdata[7:0];
	assign in_qual    = s_tdata[15:8];
	assign id_m1      = in_id - 8'd1;
	assign id_known   = (in_id != '0) && (in_id <= ID_W'(count_q));
	assign cur_leader = leader_valid_q ? leader_q : '0;
	assign age_ext    = CW'(rd_age);
	assign age_online = age_ext <= CW'(timeout_q);
	assign s1_id      = ID_W'(idx_s1) + 8'd1;
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			nllt_pkg::ADDR_TIMEOUT: prdata = 32'(timeout_q);
			nllt_pkg::ADDR_CHANNEL: prdata = 32'(chan_q);
			default:                prdata = '0;
		endcase
	end

	// memory port steering
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = idx_s1;
		wr_online = rd_online;
		wr_qual   = rd_qual;
		wr_age    = rd_age;
		rd_en     = 1'b0;
		rd_addr   = idx_q[IW-1:0];
		if (accept && s_tuser == nllt_pkg::REQ_JOIN && count_q != CNT_W'(MAX_NODES)) begin
			wr_en     = 1'b1;
			wr_addr   = count_q[IW-1:0];
			wr_online = 1'b1;
			wr_qual   = '0;
			wr_age    = '0;
		end else if (accept && s_tuser == nllt_pkg::REQ_TELEM && id_known) begin
			wr_en     = 1'b1;
			wr_addr   = id_m1[IW-1:0];
			wr_online = 1'b1;
			wr_qual   = in_qual;
			wr_age    = '0;
		end else if (accept && s_tuser == nllt_pkg::REQ_QUERY) begin
			rd_en   = id_known;
			rd_addr = id_m1[IW-1:0];
		end else if (state_q == ST_WALK) begin
			rd_en = (idx_q < count_q);
			wr_en = vld_s1;
			if (is_eval_q) begin
				wr_online = age_online;
			end else begin
				wr_age = (rd_age == AGE_MAX) ? rd_age : rd_age + 1'b1;
			end
		end
	end

	nllt_store #(
		.DEPTH (MAX_NODES),
		.AGE_W (AGE_WIDTH),
		.IW    (IW)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_online (wr_online),
		.wr_qual   (wr_qual),
		.wr_age    (wr_age),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_online (rd_online),
		.rd_qual   (rd_qual),
		.rd_age    (rd_age)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			is_eval_q      <= 1'b0;
			idx_q          <= '0;
			vld_s1         <= 1'b0;
			idx_s1         <= '0;
			count_q        <= '0;
			leader_q       <= '0;
			leader_valid_q <= 1'b0;
			timeout_q      <= 16'd2;
			chan_q         <= 7'd2;
			lead_on_q      <= 1'b0;
			found_q        <= 1'b0;
			best_idx_q     <= '0;
			best_age_q     <= '0;
			res_kind_q     <= '0;
			res_id_q       <= '0;
			res_leader_q   <= '0;
			res_chan_q     <= '0;
			res_online_q   <= 1'b0;
			res_qual_q     <= '0;
			res_age_q      <= '0;
			m_tvalid       <= 1'b0;
			m_tuser        <= '0;
			m_tdata        <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					nllt_pkg::ADDR_TIMEOUT: timeout_q <= pwdata[15:0];
					nllt_pkg::ADDR_CHANNEL: chan_q    <= pwdata[6:0];
					default:                timeout_q <= timeout_q;
				endcase
			end
			if (state_q == ST_EMIT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
				m_tuser  <= res_kind_q;
				m_tdata  <= {res_age_q, res_qual_q, res_online_q, res_chan_q,
					res_leader_q, res_id_q};
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_online_q <= 1'b0;
						res_qual_q   <= '0;
						res_age_q    <= '0;
						idx_q        <= '0;
						vld_s1       <= 1'b0;
						lead_on_q    <= 1'b0;
						found_q      <= 1'b0;
						case (s_tuser)
							nllt_pkg::REQ_JOIN: begin
								state_q <= ST_EMIT;
								if (count_q == CNT_W'(MAX_NODES)) begin
									res_kind_q   <= nllt_pkg::KIND_FULL;
									res_id_q     <= '0;
									res_leader_q <= cur_leader;
									res_chan_q   <= '0;
								end else begin
									res_kind_q <= nllt_pkg::KIND_JOIN_OK;
									res_id_q   <= ID_W'(count_q) + 8'd1;
									res_chan_q <= chan_q;
									count_q    <= count_q + 1'b1;
									if (count_q == '0) begin
										leader_q       <= 8'd1;
										leader_valid_q <= 1'b1;
										res_leader_q   <= 8'd1;
									end else begin
										res_leader_q   <= cur_leader;
									end
								end
							end
							nllt_pkg::REQ_TICK: begin
								is_eval_q  <= 1'b0;
								res_chan_q <= '0;
								state_q    <= ST_WALK;
							end
							nllt_pkg::REQ_EVAL: begin
								is_eval_q  <= 1'b1;
								res_chan_q <= '0;
								state_q    <= ST_WALK;
							end
							nllt_pkg::REQ_QUERY: begin
								res_id_q     <= in_id;
								res_leader_q <= cur_leader;
								res_chan_q   <= '0;
								if (id_known) begin
									res_kind_q <= nllt_pkg::KIND_STATUS;
									state_q    <= ST_QRD;
								end else begin
									res_kind_q <= nllt_pkg::KIND_UNKNOWN;
									state_q    <= ST_EMIT;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_QRD: begin
					res_online_q <= rd_online;
					res_qual_q   <= rd_qual;
					res_age_q    <= (age_ext > CW'(16'hFFFF)) ? 16'hFFFF : age_ext[15:0];
					state_q      <= ST_EMIT;
				end
				ST_WALK: begin
					vld_s1 <= rd_en;
					idx_s1 <= idx_q[IW-1:0];
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (vld_s1 && is_eval_q && age_online) begin
						if (s1_id == leader_q) begin
							lead_on_q <= 1'b1;
						end
						if (!found_q || rd_age < best_age_q) begin
							found_q    <= 1'b1;
							best_idx_q <= idx_s1;
							best_age_q <= rd_age;
						end
					end
					if (!rd_en && !vld_s1) begin
						state_q <= is_eval_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (!(leader_valid_q && lead_on_q)) begin
						leader_valid_q <= found_q;
						if (found_q) begin
							leader_q     <= ID_W'(best_idx_q) + 8'd1;
							res_kind_q   <= nllt_pkg::KIND_LEADER;
							res_id_q     <= ID_W'(best_idx_q) + 8'd1;
							res_leader_q <= ID_W'(best_idx_q) + 8'd1;
							state_q      <= ST_EMIT;
						end else begin
							state_q      <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond table size");

	a_leader_known: assert property (@(posedge clk) disable iff (!arst_n)
		leader_valid_q |-> (leader_q != '0) && (leader_q <= ID_W'(count_q)))
		else $error("leader id outside member range");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same entry in one cycle");

	a_leader_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == nllt_pkg::KIND_LEADER) |-> (m_tdata[7:0] == m_tdata[15:8]))
		else $error("new leader word disagrees with leader id");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && !rd_en && !vld_s1) |=> (state_q != ST_WALK))
		else $error("sweep did not finish");

endmodule

`default_nettype wire

/* tb/sv/tb_node_liveness_leader_table.sv */
// ----------------------------------------------------------------------------
// tb_node_liveness_leader_table
// Self-checking bench for the member table: joins, telemetry, ageing,
// liveness evaluation with leader election, and entry queries. Words are
// driven from a queue with random gaps and the reply stream is stalled at
// random; every reply is checked field by field against a local model of
// the table. Settings go through the register port between phases.
// ----------------------------------------------------------------------------
module tb_node_liveness_leader_table;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REQ_W     = nllt_pkg::REQ_W;
	localparam int KIND_W    = nllt_pkg::KIND_W;
	localparam int ID_W      = nllt_pkg::ID_W;
	localparam int QUAL_W    = nllt_pkg::QUAL_W;
	localparam int CHAN_W    = nllt_pkg::CHAN_W;
	localparam int TO_W      = nllt_pkg::TO_W;
	localparam int OUT_AGE_W = nllt_pkg::OUT_AGE_W;

	localparam int MAX_NODES = 16;
	localparam int AGE_WIDTH = 16;
	localparam logic [AGE_WIDTH-1:0] AGE_SAT = '1;
	localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;
	localparam logic [TO_W-1:0]   RESET_TIMEOUT = 16'd2;
	localparam logic [CHAN_W-1:0] RESET_CHANNEL = 7'd2;
	localparam int SETTLE_CYCLES = 2 * MAX_NODES + 8;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [ID_W-1:0]   id;
		logic [QUAL_W-1:0] qual;
		logic [3:0]        gap;
	} req_word_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [ID_W-1:0]      rid;
		logic [ID_W-1:0]      leader;
		logic [CHAN_W-1:0]    chan;
		logic                 online;
		logic [QUAL_W-1:0]    qual;
		logic [OUT_AGE_W-1:0] age;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [15:0] s_tdata = '0;  // node_id[7:0], quality_in[15:8]
	logic [2:0]  s_tuser = '0;  // req_type[2:0]
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [47:0] m_tdata;       // result_id, leader_id, channel_out, online_out,
	                            // quality_out, age_out
	wire  [2:0]  m_tuser;       // result_kind[2:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	node_liveness_leader_table #(
		.MAX_NODES(MAX_NODES),
		.AGE_WIDTH(AGE_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// local copy of the table
	int unsigned                member_count = 0;
	logic                       member_online [MAX_NODES];
	logic [AGE_WIDTH-1:0]       member_age [MAX_NODES];
	logic [QUAL_W-1:0]          member_quality [MAX_NODES];
	int unsigned                leader_slot = 0;
	logic                       leader_ok = 1'b0;
	logic [TO_W-1:0]            shadow_timeout = RESET_TIMEOUT;
	logic [CHAN_W-1:0]          shadow_channel = RESET_CHANNEL;

	req_word_t stim_words[$];
	reply_t    pending_replies[$];
	req_word_t cur_word;
	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned gap_count = 0;
	int unsigned replies_seen = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned fault_count = 0;
	int unsigned leader_news = 0;
	int unsigned refusals = 0;
	int unsigned status_replies = 0;
	int unsigned cycle_count = 0;

	function automatic logic [ID_W-1:0] current_leader();
		return leader_ok ? leader_slot[ID_W-1:0] : '0;
	endfunction

	function automatic bit table_update(input req_word_t w, output reply_t r);
		bit          found;
		int unsigned best;
		found = 0;
		best  = 0;
		r     = '0;
		case (w.req)
			nllt_pkg::REQ_JOIN: begin
				r.leader = current_leader();
				if (member_count >= MAX_NODES) begin
					r.kind = nllt_pkg::KIND_FULL;
					r.leader = current_leader();
					return 1;
				end
				member_online[member_count]  = 1'b1;
				member_age[member_count]     = '0;
				member_quality[member_count] = '0;
				member_count++;
				if (member_count == 1) begin
					leader_slot = 1;
					leader_ok   = 1'b1;
				end
				r.kind   = nllt_pkg::KIND_JOIN_OK;
				r.rid    = member_count[ID_W-1:0];
				r.leader = current_leader();
				r.chan   = shadow_channel;
				return 1;
			end
			nllt_pkg::REQ_TELEM: begin
				if (w.id >= 1 && w.id <= member_count) begin
					member_quality[w.id-1] = w.qual;
					member_age[w.id-1]     = '0;
					member_online[w.id-1]  = 1'b1;
				end
				return 0;
			end
			nllt_pkg::REQ_TICK: begin
				for (int i = 0; i < member_count; i++)
					if (member_age[i] != AGE_SAT)
						member_age[i]++;
				return 0;
			end
			nllt_pkg::REQ_EVAL: begin
				for (int i = 0; i < member_count; i++)
					member_online[i] = (member_age[i] <= shadow_timeout);
				if (leader_ok && (leader_slot < 1 || leader_slot > member_count ||
						!member_online[leader_slot-1]))
					leader_ok = 1'b0;
				if (leader_ok)
					return 0;
				for (int i = 0; i < member_count; i++) begin
					if (member_online[i] && (!found || member_age[i] < member_age[best])) begin
						found = 1;
						best  = i;
					end
				end
				if (!found)
					return 0;
				leader_slot = best + 1;
				leader_ok   = 1'b1;
				r.kind   = nllt_pkg::KIND_LEADER;
				r.rid    = leader_slot[ID_W-1:0];
				r.leader = current_leader();
				return 1;
			end
			nllt_pkg::REQ_QUERY: begin
				r.rid    = w.id;
				r.leader = current_leader();
				if (w.id < 1 || w.id > member_count) begin
					r.kind = nllt_pkg::KIND_UNKNOWN;
					return 1;
				end
				r.kind   = nllt_pkg::KIND_STATUS;
				r.online = member_online[w.id-1];
				r.qual   = member_quality[w.id-1];
				r.age    = member_age[w.id-1];
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// sender
	always @(posedge clk) begin
		reply_t r;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (table_update(cur_word, r)) begin
					pending_replies = {pending_replies, r};
					if (r.kind == nllt_pkg::KIND_LEADER)
						leader_news++;
					if (r.kind == nllt_pkg::KIND_FULL)
						refusals++;
					if (r.kind == nllt_pkg::KIND_STATUS)
						status_replies++;
				end
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (stim_words.size() != 0 && gap_count >= stim_words[0].gap) begin
					cur_word = stim_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_word.qual, cur_word.id};
					s_tuser  <= cur_word.req;
					gap_count = 0;
				end else begin
					s_tvalid <= 1'b0;
					if (stim_words.size() != 0)
						gap_count++;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// receiver
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind   = m_tuser;
				got.rid    = m_tdata[7:0];
				got.leader = m_tdata[15:8];
				got.chan   = m_tdata[22:16];
				got.online = m_tdata[23];
				got.qual   = m_tdata[31:24];
				got.age    = m_tdata[47:32];
				if (pending_replies.size() == 0) begin
					$error("reply word with nothing expected (kind %0d)", got.kind);
					fault_count++;
				end else begin
					want = pending_replies.pop_front();
					check_field("result_kind", want.kind, got.kind);
					check_field("result_id", want.rid, got.rid);
					check_field("leader_id", want.leader, got.leader);
					check_field("channel_out", want.chan, got.chan);
					check_field("online_out", want.online, got.online);
					check_field("quality_out", want.qual, got.qual);
					check_field("age_out", want.age, got.age);
				end
				replies_seen++;
				stall_left = (replies_seen % 200 < 30) ? 0 : $urandom_range(0, 12);
				if (replies_seen == 80 || replies_seen == 500)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("watchdog expired after %0d cycles", cycle_count);
			$display("tb_node_liveness_leader_table: errors");
			$finish;
		end
	end

	task automatic push_word(input logic [REQ_W-1:0] req, input int unsigned id,
			input int unsigned qual, input bit calm);
		req_word_t w;
		w.req  = req;
		w.id   = id[ID_W-1:0];
		w.qual = qual[QUAL_W-1:0];
		w.gap  = calm ? 4'd0 : 4'($urandom_range(0, 12));
		stim_words = {stim_words, w};
		words_queued++;
	endtask

	task automatic queue_random(input int unsigned n);
		int unsigned k;
		int unsigned roll;
		int unsigned id;
		bit calm;
		k = 0;
		while (k < n) begin
			roll = $urandom_range(0, 99);
			id   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
				: $urandom_range(1, MAX_NODES);
			calm = (k % 150) < 25;
			if (roll < 30)
				push_word(nllt_pkg::REQ_TELEM, id, $urandom_range(0, 255), calm);
			else if (roll < 55)
				push_word(nllt_pkg::REQ_TICK, id, $urandom_range(0, 255), calm);
			else if (roll < 70)
				push_word(nllt_pkg::REQ_EVAL, id, $urandom_range(0, 255), calm);
			else if (roll < 90)
				push_word(nllt_pkg::REQ_QUERY, id, $urandom_range(0, 255), calm);
			else if (roll < 95)
				push_word(nllt_pkg::REQ_JOIN, id, $urandom_range(0, 255), calm);
			else
				push_word(REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), id,
					$urandom_range(0, 255), calm);
			if (roll < 95)
				k++;
		end
	endtask

	task automatic wait_idle();
		int unsigned spin;
		spin = 0;
		while (stim_words.size() != 0 || words_taken != words_queued)
			@(posedge clk);
		while (pending_replies.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == nllt_pkg::ADDR_TIMEOUT)
			shadow_timeout = val[TO_W-1:0];
		else
			shadow_channel = val[CHAN_W-1:0];
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, unknown ids, spare request codes, first joiner
		push_word(nllt_pkg::REQ_QUERY, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_EVAL, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_TICK, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_TELEM, 1, 8'h3C, 1'b0);
		for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++)
			push_word(REQ_W'(c), $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
		push_word(nllt_pkg::REQ_JOIN, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_QUERY, 1, 0, 1'b0);
		push_word(nllt_pkg::REQ_TELEM, 1, 255, 1'b0);
		push_word(nllt_pkg::REQ_QUERY, 1, 0, 1'b0);
		repeat (3) push_word(nllt_pkg::REQ_TICK, 0, 0, 1'b1);
		// leader ages out with nobody to replace it
		push_word(nllt_pkg::REQ_EVAL, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_QUERY, 1, 0, 1'b0);
		push_word(nllt_pkg::REQ_JOIN, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_EVAL, 0, 0, 1'b0);
		wait_idle();

		reg_write(nllt_pkg::ADDR_TIMEOUT, 32'd30);
		reg_write(nllt_pkg::ADDR_CHANNEL, 32'd125);
		// age both entries past the timeout
		push_word(nllt_pkg::REQ_TELEM, 1, 0, 1'b0);
		repeat (40) push_word(nllt_pkg::REQ_TICK, 0, 0, 1'b1);
		push_word(nllt_pkg::REQ_QUERY, 1, 0, 1'b0);
		push_word(nllt_pkg::REQ_QUERY, 2, 0, 1'b0);
		push_word(nllt_pkg::REQ_EVAL, 0, 0, 1'b0);
		// equal ages: lowest id wins
		push_word(nllt_pkg::REQ_TELEM, 1, 8'hA5, 1'b0);
		push_word(nllt_pkg::REQ_TELEM, 2, 8'h5A, 1'b0);
		push_word(nllt_pkg::REQ_EVAL, 0, 0, 1'b0);
		repeat (4) push_word(nllt_pkg::REQ_JOIN, 0, 0, 1'b0);
		push_word(nllt_pkg::REQ_QUERY, 255, 0, 1'b0);
		push_word(nllt_pkg::REQ_QUERY, 2, 0, 1'b0);
		wait_idle();

		reg_write(nllt_pkg::ADDR_TIMEOUT, 32'd1);
		reg_write(nllt_pkg::ADDR_CHANNEL, 32'd0);
		queue_random(450);
		wait_idle();

		reg_write(nllt_pkg::ADDR_TIMEOUT, $urandom_range(2, 12));
		reg_write(nllt_pkg::ADDR_CHANNEL, $urandom_range(1, 124));
		queue_random(500);
		wait_idle();

		reg_write(nllt_pkg::ADDR_TIMEOUT, 32'd65534);
		reg_write(nllt_pkg::ADDR_CHANNEL, 32'd125);
		queue_random(450);
		wait_idle();

		if (pending_replies.size() != 0) begin
			$error("%0d expected replies never arrived", pending_replies.size());
			fault_count++;
		end
		$display("Covered %0d words in, %0d replies checked (%0d status, %0d refused joins).",
			words_taken, replies_seen, status_replies, refusals);
		$display("Leader announcements: %0d; members at end: %0d.", leader_news, member_count);
		if (fault_count == 0)
			$display("tb_node_liveness_leader_table: clean");
		else
			$display("tb_node_liveness_leader_table: errors");
		$finish;
	end

endmodule
